@@ sv/sli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared constants and types for the sorted list insert and delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ELEMENT   = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic ins;
        logic del;
        logic rot;
    } cell_op_t;

endpackage

@@ sv/sli_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_cell
// One list position: holds an entry and shifts it toward either neighbor.
// ----------------------------------------------------------------------------
module sli_cell
    import sli_pkg::*;
(
    input  logic               aclk,
    input  cell_op_t           op,
    input  logic signed [31:0] new_value,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] right_value,
    input  logic signed [31:0] wrap_value,
    input  logic               occ,
    input  logic               occ_right,
    input  logic               gt_left,
    input  logic               hit_left,
    output logic signed [31:0] value,
    output logic               gt,
    output logic               hit
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    assign value = value_reg;
    assign gt    = occ && (value_reg > new_value);
    assign hit   = hit_left || (occ && (value_reg == new_value));

    always_comb begin
        value_next = value_reg;
        if (op.ins) begin
            if (gt_left) begin
                value_next = left_value;
            end else if (gt || !occ) begin
                value_next = new_value;
            end
        end else if (op.del) begin
            if (hit) begin
                value_next = right_value;
            end
        end else if (op.rot) begin
            value_next = occ_right ? right_value : wrap_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

@@ sv/sorted_list_insert_delete.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending list of signed values kept in a chain of cells.
// ----------------------------------------------------------------------------
// Channel | Ports                       | Direction | Word
// s_      | s_valid s_ready s_cmd s_value | in      | one command
// m_      | m_valid m_ready m_status m_element m_last | out | one result
//
// Insert and delete act on the whole chain: every cell compares and shifts at once.
// A read of n entries holds the input off until its n words are emitted while the
// chain rotates one position per emitted word; an empty read gives one word.
// Reset clears the entry count, the read sequencer and the output valid flag.
// A stalled result holds the output register; the input waits behind it and during a read.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_element,
    output logic               m_last
);

    state_t             state_reg,     state_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [CNT_W-1:0]   remain_reg,    remain_next;
    logic               m_valid_reg,   m_valid_next;
    status_t            m_status_reg,  m_status_next;
    logic signed [31:0] m_element_reg, m_element_next;
    logic               m_last_reg,    m_last_next;

    cell_op_t           op;
    logic               out_free;
    logic               accept;

    logic signed [31:0] cell_value [CAPACITY];
    logic               cell_gt    [CAPACITY];
    logic               cell_hit   [CAPACITY];
    logic               cell_occ   [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            assign cell_occ[i] = count_reg > CNT_W'(i);
            if (i == 0) begin : g_first
                sli_cell u_cell (
                    .aclk        (aclk),
                    .op          (op),
                    .new_value   (s_value),
                    .left_value  (cell_value[0]),
                    .right_value (cell_value[1]),
                    .wrap_value  (cell_value[0]),
                    .occ         (cell_occ[0]),
                    .occ_right   (cell_occ[1]),
                    .gt_left     (1'b0),
                    .hit_left    (1'b0),
                    .value       (cell_value[0]),
                    .gt          (cell_gt[0]),
                    .hit         (cell_hit[0])
                );
            end else if (i == CAPACITY - 1) begin : g_last
                sli_cell u_cell (
                    .aclk        (aclk),
                    .op          (op),
                    .new_value   (s_value),
                    .left_value  (cell_value[i-1]),
                    .right_value (cell_value[i]),
                    .wrap_value  (cell_value[0]),
                    .occ         (cell_occ[i]),
                    .occ_right   (1'b0),
                    .gt_left     (cell_gt[i-1]),
                    .hit_left    (cell_hit[i-1]),
                    .value       (cell_value[i]),
                    .gt          (cell_gt[i]),
                    .hit         (cell_hit[i])
                );
            end else begin : g_mid
                sli_cell u_cell (
                    .aclk        (aclk),
                    .op          (op),
                    .new_value   (s_value),
                    .left_value  (cell_value[i-1]),
                    .right_value (cell_value[i+1]),
                    .wrap_value  (cell_value[0]),
                    .occ         (cell_occ[i]),
                    .occ_right   (cell_occ[i+1]),
                    .gt_left     (cell_gt[i-1]),
                    .hit_left    (cell_hit[i-1]),
                    .value       (cell_value[i]),
                    .gt          (cell_gt[i]),
                    .hit         (cell_hit[i])
                );
            end
        end
    endgenerate

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_element_next = m_element_reg;
        m_last_next    = m_last_reg;
        op             = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_INSERT: begin
                            m_valid_next   = 1'b1;
                            m_element_next = '0;
                            m_last_next    = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                m_status_next = ST_FULL;
                            end else begin
                                op.ins        = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                m_status_next = ST_INSERTED;
                            end
                        end
                        CMD_DELETE: begin
                            m_valid_next   = 1'b1;
                            m_element_next = '0;
                            m_last_next    = 1'b1;
                            if (cell_hit[CAPACITY-1]) begin
                                op.del        = 1'b1;
                                count_next    = count_reg - CNT_W'(1);
                                m_status_next = ST_DELETED;
                            end else begin
                                m_status_next = ST_NOT_FOUND;
                            end
                        end
                        CMD_READ: begin
                            if (count_reg == '0) begin
                                m_valid_next   = 1'b1;
                                m_status_next  = ST_EMPTY;
                                m_element_next = '0;
                                m_last_next    = 1'b1;
                            end else begin
                                remain_next = count_reg;
                                state_next  = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    op.rot         = 1'b1;
                    m_valid_next   = 1'b1;
                    m_status_next  = ST_ELEMENT;
                    m_element_next = cell_value[0];
                    m_last_next    = (remain_reg == CNT_W'(1));
                    remain_next    = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg  <= m_status_next;
        m_element_reg <= m_element_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_element = m_element_reg;
    assign m_last    = m_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !s_ready)
        else $error("input ready during a read");

    a_read_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> $stable(count_reg))
        else $error("entry count changed during a read");

    a_remain_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (remain_reg != '0 && remain_reg <= count_reg))
        else $error("read counter out of range");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_ELEMENT) |-> (m_last && m_element == '0))
        else $error("status word without last or with nonzero element");
`endif

endmodule
